>>> sv/accumulator_cpu_execute_macros.svh
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_macros
// assertion macros shared by the accumulator cpu execute block
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS
`define ACE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ACE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ACE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ACE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> sv/accexe_pkg.sv
// ----------------------------------------------------------------------------
// accexe_pkg
// types and constants of the accumulator cpu execute block
// ----------------------------------------------------------------------------
package accexe_pkg;

   localparam int DEF_RAM_DEPTH = 256;
   localparam int DEF_REG_COUNT = 6;

   localparam logic [7:0] OP_AND  = 8'h01;
   localparam logic [7:0] OP_LDA  = 8'h02;
   localparam logic [7:0] OP_LDR  = 8'h03;
   localparam logic [7:0] OP_LDI  = 8'h04;
   localparam logic [7:0] OP_STA  = 8'h05;
   localparam logic [7:0] OP_STR  = 8'h06;
   localparam logic [7:0] OP_OR   = 8'h07;
   localparam logic [7:0] OP_XOR  = 8'h08;
   localparam logic [7:0] OP_SUB  = 8'h09;
   localparam logic [7:0] OP_ADD  = 8'h0A;
   localparam logic [7:0] OP_DIV  = 8'h0B;
   localparam logic [7:0] OP_MUL  = 8'h0C;
   localparam logic [7:0] OP_NOP  = 8'h0D;
   localparam logic [7:0] OP_NOT  = 8'h0E;
   localparam logic [7:0] OP_JMPR = 8'h0F;
   localparam logic [7:0] OP_JMP  = 8'h10;
   localparam logic [7:0] OP_RST  = 8'h11;
   localparam logic [7:0] OP_BEQ  = 8'h12;
   localparam logic [7:0] OP_BNE  = 8'h13;
   localparam logic [7:0] OP_BC   = 8'h14;
   localparam logic [7:0] OP_BNC  = 8'h15;
   localparam logic [7:0] OP_BGT  = 8'h16;
   localparam logic [7:0] OP_BLT  = 8'h17;
   localparam logic [7:0] OP_SEC  = 8'h18;
   localparam logic [7:0] OP_CLC  = 8'h19;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADREG  = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam int DIV_STEPS = 8;

   typedef struct packed {
      logic [7:0] action;
      logic [7:0] operand_first;
      logic [7:0] operand_second;
   } req_type;

   typedef struct packed {
      logic [7:0] next_pc;
      logic [7:0] acc_value;
      logic       carry_flag;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic div_step;
      logic clear;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic is_rst;
      logic clear_done;
   } dp_stat_type;

endpackage

>>> sv/accexe_ctrl.sv
// ----------------------------------------------------------------------------
// accexe_ctrl
// sequencing state machine of the accumulator cpu execute block
// ----------------------------------------------------------------------------
module accexe_ctrl
   import accexe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_FETCH, S_DIV, S_CLEAR, S_COMMIT, S_RESP
   } state_type;

   localparam int CW = $clog2(DIV_STEPS);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           req_ready_ff, req_ready_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            cnt_in    = '0;
            if (stat.is_rst) begin
               state_in = S_CLEAR;
            end else begin
               state_in = stat.need_div ? S_DIV : S_COMMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      req_ready_in = (state_in == S_IDLE);
      rsp_valid_in = (state_in == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/accexe_dp.sv
// ----------------------------------------------------------------------------
// accexe_dp
// machine state, data ram, divider and result register
// ----------------------------------------------------------------------------
module accexe_dp
   import accexe_pkg::*;
#(
   parameter int RAM_DEPTH = DEF_RAM_DEPTH,
   parameter int REG_COUNT = DEF_REG_COUNT
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(RAM_DEPTH);
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   logic [7:0]  op_ff, o1_ff, o2_ff;
   logic [7:0]  pc_ff, pc_in;
   logic [7:0]  acc_ff, acc_in;
   logic        carry_ff, carry_in;
   logic [7:0]  regs_ff [REG_COUNT];
   logic [7:0]  ram_mem [RAM_DEPTH];
   logic [7:0]  ram_q_ff;
   logic        ram_hit_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]  rem_ff, quo_ff;
   rsp_type     rsp_ff;

   logic        reg_ok;
   logic [RW-1:0] ridx;
   logic [7:0]  rv;
   logic [7:0]  ram_rd;
   logic [7:0]  rd_addr;
   logic        rd_in_range;
   logic        clr_last;
   logic [8:0]  div_r;
   logic [8:0]  sum9;
   logic [15:0] prod;
   logic        uses_reg;
   logic [1:0]  st_in;
   logic        reg_we;
   logic [7:0]  reg_wd;
   logic        ram_we;
   logic [7:0]  ram_wa, ram_wd;
   logic        ram_wa_ok;
   logic        clr_all;

   assign reg_ok = (o1_ff < 8'(REG_COUNT));
   assign ridx   = o1_ff[RW-1:0];
   assign rv     = reg_ok ? regs_ff[ridx] : 8'd0;
   assign ram_rd = ram_hit_ff ? ram_q_ff : 8'd0;
   assign rd_addr     = (op_ff == OP_LDA) ? o1_ff : o2_ff;
   assign rd_in_range = ({1'b0, rd_addr} < 9'(RAM_DEPTH));
   assign clr_last    = (clr_addr_ff == AW'(RAM_DEPTH - 1));
   assign clr_addr_in = clr_last ? '0 : clr_addr_ff + 1'b1;
   assign div_r = {rem_ff, quo_ff[7]};
   assign sum9  = {1'b0, acc_ff} + {1'b0, rv};
   assign prod  = acc_ff * rv;
   assign stat.need_div   = (op_ff == OP_DIV) && (rv != 8'd0);
   assign stat.is_rst     = (op_ff == OP_RST);
   assign stat.clear_done = clr_last;

   always_comb begin
      uses_reg = 1'b0;
      case (op_ff)
         OP_AND, OP_LDR, OP_LDI, OP_STR, OP_OR, OP_XOR, OP_SUB, OP_ADD,
         OP_DIV, OP_MUL, OP_NOT, OP_JMPR, OP_BEQ, OP_BNE, OP_BGT,
         OP_BLT: uses_reg = 1'b1;
         default: uses_reg = 1'b0;
      endcase
   end

   always_comb begin
      pc_in    = pc_ff + 8'd2;
      acc_in   = acc_ff;
      carry_in = carry_ff;
      st_in    = (uses_reg && !reg_ok) ? ST_BADREG : ST_OK;
      reg_we   = 1'b0;
      reg_wd   = 8'd0;
      ram_we   = 1'b0;
      ram_wa   = o1_ff;
      ram_wd   = acc_ff;
      clr_all  = 1'b0;
      case (op_ff)
         OP_AND: acc_in = acc_ff & rv;
         OP_LDA: acc_in = ram_rd;
         OP_LDR: begin
            reg_we = 1'b1;
            reg_wd = ram_rd;
            pc_in  = pc_ff + 8'd3;
         end
         OP_LDI: begin
            reg_we = 1'b1;
            reg_wd = o2_ff;
            pc_in  = pc_ff + 8'd3;
         end
         OP_STA: ram_we = 1'b1;
         OP_STR: begin
            ram_we = 1'b1;
            ram_wa = o2_ff;
            ram_wd = rv;
            pc_in  = pc_ff + 8'd3;
         end
         OP_OR:  acc_in = acc_ff | rv;
         OP_XOR: acc_in = acc_ff ^ rv;
         OP_SUB: begin
            if (acc_ff < rv) begin
               carry_in = 1'b1;
            end
            acc_in = acc_ff - rv;
         end
         OP_ADD: begin
            if (sum9[8]) begin
               carry_in = 1'b1;
            end
            acc_in = sum9[7:0];
         end
         OP_DIV: begin
            if (rv == 8'd0) begin
               carry_in = 1'b1;
               st_in    = ST_DIVZERO;
            end else begin
               acc_in = quo_ff;
            end
         end
         OP_MUL: begin
            if (prod[15:8] != 8'd0) begin
               carry_in = 1'b1;
            end
            acc_in = prod[7:0];
         end
         OP_NOP: pc_in = pc_ff + 8'd1;
         OP_NOT: begin
            reg_we = 1'b1;
            reg_wd = ~rv;
         end
         OP_JMPR: pc_in = rv;
         OP_JMP:  pc_in = o1_ff;
         OP_RST: begin
            clr_all  = 1'b1;
            pc_in    = 8'd0;
            acc_in   = 8'd0;
            carry_in = 1'b0;
         end
         OP_BEQ: pc_in = (acc_ff == rv) ? o2_ff : pc_ff + 8'd3;
         OP_BNE: pc_in = (acc_ff != rv) ? o2_ff : pc_ff + 8'd3;
         OP_BGT: pc_in = (acc_ff > rv) ? o2_ff : pc_ff + 8'd3;
         OP_BLT: pc_in = (acc_ff < rv) ? o2_ff : pc_ff + 8'd3;
         OP_BC:  pc_in = carry_ff ? o1_ff : pc_ff + 8'd2;
         OP_BNC: pc_in = carry_ff ? pc_ff + 8'd2 : o1_ff;
         OP_SEC: begin
            carry_in = 1'b1;
            pc_in    = pc_ff + 8'd1;
         end
         OP_CLC: begin
            carry_in = 1'b0;
            pc_in    = pc_ff + 8'd1;
         end
         default: begin
            st_in = ST_UNKNOWN;
            pc_in = pc_ff + 8'd1;
         end
      endcase
   end

   assign ram_wa_ok = ({1'b0, ram_wa} < 9'(RAM_DEPTH));

   // transaction operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_data.action;
         o1_ff <= req_data.operand_first;
         o2_ff <= req_data.operand_second;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= 8'd0;
         acc_ff   <= 8'd0;
         carry_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= 8'd0;
         end
      end else if (cmd.commit) begin
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         carry_ff <= carry_in;
         if (clr_all) begin
            for (int i = 0; i < REG_COUNT; i++) begin
               regs_ff[i] <= 8'd0;
            end
         end else if (reg_we && reg_ok) begin
            regs_ff[ridx] <= reg_wd;
         end
      end
   end

   // ram clearing pass, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // data ram
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         ram_mem[clr_addr_ff] <= 8'd0;
      end else if (cmd.commit && ram_we && ram_wa_ok && !clr_all) begin
         ram_mem[ram_wa[AW-1:0]] <= ram_wd;
      end
      if (cmd.fetch) begin
         ram_q_ff   <= ram_mem[rd_addr[AW-1:0]];
         ram_hit_ff <= rd_in_range;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rem_ff <= 8'd0;
         quo_ff <= acc_ff;
      end else if (cmd.div_step) begin
         if (div_r >= {1'b0, rv}) begin
            rem_ff <= 8'(div_r - {1'b0, rv});
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            rem_ff <= div_r[7:0];
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.next_pc    <= pc_in;
         rsp_ff.acc_value  <= acc_in;
         rsp_ff.carry_flag <= carry_in;
         rsp_ff.status     <= st_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/accumulator_cpu_execute.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// executes one instruction of an 8-bit accumulator machine per transaction
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_data (action, operands)
// rsp      out        rsp_valid / rsp_ready  rsp_data (pc, acc, carry, status)
//
// one transaction at a time: rsp_valid rises after the fetch and commit states;
// a divide by a nonzero register runs the 8-step restoring divider in between
// a reset instruction adds the ram clearing pass before commit
// after reset the same clearing pass holds req_ready low until the ram is cleared
// synchronous reset clears pc, accumulator, registers and carry
// req_ready stays low until the pending response is taken
// ----------------------------------------------------------------------------
module accumulator_cpu_execute
   import accexe_pkg::*;
#(
   parameter int RAM_DEPTH = DEF_RAM_DEPTH,
   parameter int REG_COUNT = DEF_REG_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "accumulator_cpu_execute_macros.svh"

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   accexe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   accexe_dp #(
      .RAM_DEPTH (RAM_DEPTH),
      .REG_COUNT (REG_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   `ACE_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `ACE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `ACE_ASSERT_NEXT(a_rsp_release, clock, reset, rsp_valid && rsp_ready, req_ready && !rsp_valid)
   `ACE_ASSERT_NEXT(a_commit_resp, clock, reset, cmd.commit, rsp_valid)

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression of the accumulator cpu execute block: directed instructions
// cover every opcode, bad registers, divide by zero, reset and branches, then
// random programs with a shadow machine predicting pc, acc, carry and status
// ----------------------------------------------------------------------------
module tb_top;
   import accexe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS  = DEF_REG_COUNT;
   localparam int MEM_BYTES = DEF_RAM_DEPTH;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   accumulator_cpu_execute DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow machine
   logic [7:0] sh_pc, sh_acc;
   logic [7:0] sh_regs [NUM_REGS];
   logic       sh_carry;
   logic [7:0] sh_ram [MEM_BYTES];
   rsp_type    pending_rsp[$];
   int         error_count = 0;
   int         cycle_count = 0;
   bit         quiet_mode = 1'b0;

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic shadow_reset();
      sh_pc = '0; sh_acc = '0; sh_carry = 1'b0;
      foreach (sh_regs[i]) sh_regs[i] = '0;
      foreach (sh_ram[i]) sh_ram[i] = '0;
   endtask

   function automatic logic [7:0] read_reg(input logic [7:0] idx, inout logic [1:0] st);
      if (idx >= NUM_REGS) begin
         st = ST_BADREG;
         return 8'h00;
      end
      return sh_regs[idx];
   endfunction

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] v, inout logic [1:0] st);
      if (idx >= NUM_REGS) st = ST_BADREG;
      else sh_regs[idx] = v;
   endtask

   task automatic execute_instruction(input req_type rq);
      logic [1:0] st;
      logic [7:0] nxt, a, v;
      logic [15:0] wide;
      st = ST_OK;
      a = sh_acc;
      nxt = sh_pc + 8'd2;
      case (rq.action)
         OP_AND: sh_acc = a & read_reg(rq.operand_first, st);
         OP_OR:  sh_acc = a | read_reg(rq.operand_first, st);
         OP_XOR: sh_acc = a ^ read_reg(rq.operand_first, st);
         OP_LDA: sh_acc = (rq.operand_first < MEM_BYTES) ? sh_ram[rq.operand_first] : 8'h00;
         OP_LDR: begin
            v = (rq.operand_second < MEM_BYTES) ? sh_ram[rq.operand_second] : 8'h00;
            write_reg(rq.operand_first, v, st);
            nxt = sh_pc + 8'd3;
         end
         OP_LDI: begin
            write_reg(rq.operand_first, rq.operand_second, st);
            nxt = sh_pc + 8'd3;
         end
         OP_STA: if (rq.operand_first < MEM_BYTES) sh_ram[rq.operand_first] = a;
         OP_STR: begin
            v = read_reg(rq.operand_first, st);
            if (rq.operand_second < MEM_BYTES) sh_ram[rq.operand_second] = v;
            nxt = sh_pc + 8'd3;
         end
         OP_SUB: begin
            v = read_reg(rq.operand_first, st);
            if (a < v) sh_carry = 1'b1;
            sh_acc = a - v;
         end
         OP_ADD: begin
            wide = a + read_reg(rq.operand_first, st);
            if (wide > 16'd255) sh_carry = 1'b1;
            sh_acc = wide[7:0];
         end
         OP_DIV: begin
            v = read_reg(rq.operand_first, st);
            if (v == 8'h00) begin
               sh_carry = 1'b1;
               st = ST_DIVZERO;
            end else sh_acc = a / v;
         end
         OP_MUL: begin
            wide = a * read_reg(rq.operand_first, st);
            if (wide > 16'd255) sh_carry = 1'b1;
            sh_acc = wide[7:0];
         end
         OP_NOP: nxt = sh_pc + 8'd1;
         OP_NOT: begin
            v = read_reg(rq.operand_first, st);
            write_reg(rq.operand_first, ~v, st);
         end
         OP_JMPR: nxt = read_reg(rq.operand_first, st);
         OP_JMP:  nxt = rq.operand_first;
         OP_RST: begin
            shadow_reset();
            nxt = 8'h00;
         end
         OP_BEQ, OP_BNE, OP_BGT, OP_BLT: begin
            bit take;
            v = read_reg(rq.operand_first, st);
            case (rq.action)
               OP_BEQ:  take = (a == v);
               OP_BNE:  take = (a != v);
               OP_BGT:  take = (a > v);
               default: take = (a < v);
            endcase
            nxt = take ? rq.operand_second : sh_pc + 8'd3;
         end
         OP_BC:  if (sh_carry) nxt = rq.operand_first;
         OP_BNC: if (!sh_carry) nxt = rq.operand_first;
         OP_SEC: begin
            sh_carry = 1'b1;
            nxt = sh_pc + 8'd1;
         end
         OP_CLC: begin
            sh_carry = 1'b0;
            nxt = sh_pc + 8'd1;
         end
         default: begin
            st = ST_UNKNOWN;
            nxt = sh_pc + 8'd1;
         end
      endcase
      sh_pc = nxt;
      pending_rsp.push_back('{next_pc: nxt, acc_value: sh_acc, carry_flag: sh_carry,
                              status: st});
   endtask

   function automatic bit idle_now();
      return !quiet_mode && ($urandom_range(99) < 10);
   endfunction

   task automatic send_instruction(input logic [7:0] op, input logic [7:0] o1,
                                   input logic [7:0] o2);
      req_type rq;
      rq = '{action: op, operand_first: o1, operand_second: o2};
      while (idle_now()) @(posedge clock);
      execute_instruction(rq);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) rsp_ready <= !idle_now();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected transaction pc", rsp_data.next_pc, 8'h00);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.next_pc !== want.next_pc)
               report("next_pc", rsp_data.next_pc, want.next_pc);
            if (rsp_data.acc_value !== want.acc_value)
               report("acc_value", rsp_data.acc_value, want.acc_value);
            if (rsp_data.carry_flag !== want.carry_flag)
               report("carry_flag", rsp_data.carry_flag, want.carry_flag);
            if (rsp_data.status !== want.status)
               report("status", rsp_data.status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("accumulator_cpu_execute regression: fail");
         $finish;
      end
   end

   function automatic logic [7:0] rand_reg();
      return ($urandom_range(9) == 0) ? 8'($urandom_range(255, NUM_REGS))
                                      : 8'($urandom_range(NUM_REGS - 1));
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'($urandom_range(15));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_load_store();
      send_instruction(OP_LDI, 8'd0, 8'hFF);
      send_instruction(OP_LDI, 8'd5, 8'h80);
      send_instruction(OP_STR, 8'd0, 8'hFF);
      send_instruction(OP_LDA, 8'hFF, 8'h00);
      send_instruction(OP_STA, 8'h00, 8'h00);
      send_instruction(OP_LDR, 8'd1, 8'h00);
      send_instruction(OP_LDI, 8'd6, 8'h12);
      send_instruction(OP_STR, 8'hFF, 8'h10);
   endtask

   task automatic test_alu();
      send_instruction(OP_AND, 8'd5, 8'h00);
      send_instruction(OP_OR,  8'd0, 8'h00);
      send_instruction(OP_XOR, 8'd5, 8'h00);
      send_instruction(OP_ADD, 8'd0, 8'h00);
      send_instruction(OP_CLC, 8'h00, 8'h00);
      send_instruction(OP_SUB, 8'd0, 8'h00);
      send_instruction(OP_MUL, 8'd5, 8'h00);
      send_instruction(OP_LDI, 8'd2, 8'h03);
      send_instruction(OP_DIV, 8'd2, 8'h00);
      send_instruction(OP_DIV, 8'd3, 8'h00);
      send_instruction(OP_NOT, 8'd3, 8'h00);
      send_instruction(OP_NOT, 8'd9, 8'h00);
   endtask

   task automatic test_flow();
      send_instruction(OP_SEC, 8'h00, 8'h00);
      send_instruction(OP_BC,  8'h40, 8'h00);
      send_instruction(OP_BNC, 8'h50, 8'h00);
      send_instruction(OP_BEQ, 8'd0, 8'hFE);
      send_instruction(OP_BNE, 8'd0, 8'h20);
      send_instruction(OP_BGT, 8'd2, 8'h30);
      send_instruction(OP_BLT, 8'd0, 8'h31);
      send_instruction(OP_JMPR, 8'd0, 8'h00);
      send_instruction(OP_JMP, 8'hFF, 8'h00);
      send_instruction(OP_NOP, 8'h00, 8'h00);
      send_instruction(8'h00, 8'hFF, 8'hFF);
      send_instruction(8'hFF, 8'h00, 8'h00);
      send_instruction(OP_RST, 8'h00, 8'h00);
      send_instruction(OP_LDA, 8'hFF, 8'h00);
   endtask

   task automatic test_random_programs(input int count);
      logic [7:0] op;
      for (int n = 0; n < count; n++) begin
         quiet_mode = (n >= count / 3) && (n < count / 2);
         case ($urandom_range(99))
            0:              op = 8'($urandom_range(255, 8'h1A));
            1:              op = 8'h00;
            2:              op = OP_RST;
            3, 4, 5, 6:     op = OP_LDI;
            default:        op = 8'($urandom_range(8'h19, 8'h01));
         endcase
         if (op == OP_RST && $urandom_range(3) != 0) op = OP_NOP;
         case (op)
            OP_LDA, OP_STA, OP_JMP, OP_BC, OP_BNC:
               send_instruction(op, rand_byte(), rand_byte());
            default:
               send_instruction(op, rand_reg(), rand_byte());
         endcase
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      shadow_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_store();
      test_alu();
      test_flow();
      test_random_programs(1750);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("accumulator_cpu_execute regression: pass");
      end else begin
         $display("accumulator_cpu_execute regression: fail");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+sv
sv/accexe_pkg.sv
sv/accexe_ctrl.sv
sv/accexe_dp.sv
sv/accumulator_cpu_execute.sv
bench/tb_top.sv
